// ----- design/bdve_pkg.sv -----
// bdve_pkg: shared types, codes and constants for the block delta varbyte encoder.
// No dependencies; used by every module of the block by scoped names.
package bdve_pkg;

	localparam int BLOCK_LEN_DEF = 64;
	localparam int QUEUE_DEPTH   = 4;
	localparam int VALUE_W       = 32;
	localparam int BYTES_W       = 9;
	localparam int NBYTES_W      = 3;
	localparam int STEP_W        = 3;
	localparam logic [BYTES_W-1:0] BYTES_MAX = 9'd511;

	// delta_mode codes (2 and 3 behave as no delta)
	localparam logic [1:0] MODE_RUN   = 2'd0;
	localparam logic [1:0] MODE_BLOCK = 2'd1;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_COUNT = 2'd1;
	localparam logic [1:0] KIND_LAST  = 2'd2;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               list_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [VALUE_W-1:0] payload;
		logic               run_last;
	} out_item_t;

	// one classified request handed from front to back
	typedef struct packed {
		logic [VALUE_W-1:0]  code;
		logic [NBYTES_W-1:0] nbytes;
		logic                closes;
		logic                emit_last;
		logic [BYTES_W-1:0]  count;
		logic [VALUE_W-1:0]  value;
	} job_t;

	typedef struct packed {
		logic              cur_valid;
		logic [STEP_W-1:0] step;
		logic [STEP_W-1:0] total;
	} back_stat_t;

endpackage

// ----- design/bdve_front.sv -----
// bdve_front: takes requests, forms the delta and its byte length, keeps block state.
// Depends on bdve_pkg.
module bdve_front #(
	parameter int BLOCK_LEN = bdve_pkg::BLOCK_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bdve_pkg::in_item_t  in_item,
	input  logic                accept,
	input  logic [1:0]          delta_mode,
	output bdve_pkg::job_t      job
);

	localparam int FILL_W = $clog2(BLOCK_LEN + 1);

	logic [bdve_pkg::VALUE_W-1:0] prev_q;
	logic [FILL_W-1:0]            fill_q;
	logic [bdve_pkg::BYTES_W-1:0] bytes_q;

	logic [bdve_pkg::VALUE_W-1:0]  base;
	logic [bdve_pkg::VALUE_W-1:0]  code;
	logic [bdve_pkg::NBYTES_W-1:0] nb;
	logic [bdve_pkg::BYTES_W:0]    bytes_sum;
	logic [bdve_pkg::BYTES_W-1:0]  bytes_sat;
	logic [FILL_W-1:0]             fill_next;
	logic                          closes;
	logic                          clear_prev;

	always_comb begin
		if (delta_mode == bdve_pkg::MODE_RUN) begin
			base = prev_q;
		end else if (delta_mode == bdve_pkg::MODE_BLOCK && fill_q != '0) begin
			base = prev_q;
		end else begin
			base = '0;
		end
		code = in_item.value - base;

		// 7-bit groups needed
		if (code[31:28] != '0)      nb = 3'd5;
		else if (code[27:21] != '0) nb = 3'd4;
		else if (code[20:14] != '0) nb = 3'd3;
		else if (code[13:7] != '0)  nb = 3'd2;
		else                        nb = 3'd1;

		bytes_sum = {1'b0, bytes_q} + (bdve_pkg::BYTES_W+1)'(nb);
		bytes_sat = (bytes_sum > {1'b0, bdve_pkg::BYTES_MAX}) ? bdve_pkg::BYTES_MAX
			: bytes_sum[bdve_pkg::BYTES_W-1:0];

		fill_next  = fill_q + FILL_W'(1);
		closes     = in_item.list_end || (fill_next == FILL_W'(BLOCK_LEN));
		clear_prev = closes && (in_item.list_end || delta_mode == bdve_pkg::MODE_BLOCK);

		job.code      = code;
		job.nbytes    = nb;
		job.closes    = closes;
		job.emit_last = closes && (delta_mode == bdve_pkg::MODE_RUN);
		job.count     = bytes_sat;
		job.value     = in_item.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			fill_q  <= '0;
			bytes_q <= '0;
		end else if (accept) begin
			prev_q  <= clear_prev ? '0 : in_item.value;
			fill_q  <= closes ? '0 : fill_next;
			bytes_q <= closes ? '0 : bytes_sat;
		end
	end

endmodule

// ----- design/bdve_queue.sv -----
// bdve_queue: short request queue between front and back, flop based.
// Depends on bdve_pkg.
module bdve_queue #(
	parameter int DEPTH = bdve_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  bdve_pkg::job_t wr_job,
	input  logic           rd,
	output bdve_pkg::job_t rd_job,
	output logic           full,
	output logic           empty
);

	localparam int AW = $clog2(DEPTH);

	bdve_pkg::job_t slot_q [DEPTH];
	logic [AW:0]    wptr_q;
	logic [AW:0]    rptr_q;

	assign full   = (wptr_q[AW] != rptr_q[AW]) && (wptr_q[AW-1:0] == rptr_q[AW-1:0]);
	assign empty  = (wptr_q == rptr_q);
	assign rd_job = slot_q[rptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + (AW+1)'(1);
			if (rd) rptr_q <= rptr_q + (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) slot_q[wptr_q[AW-1:0]] <= wr_job;
	end

endmodule

// ----- design/bdve_back.sv -----
// bdve_back: walks one request into code bytes, count and last value; output register.
// Depends on bdve_pkg.
module bdve_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bdve_pkg::job_t       head,
	input  logic                 q_empty,
	output logic                 deq,
	output bdve_pkg::out_item_t  result,
	output logic                 empty,
	input  logic                 pop,
	output bdve_pkg::back_stat_t stat
);

	bdve_pkg::job_t                cur_q;
	logic                          cur_valid_q;
	logic [bdve_pkg::VALUE_W-1:0]  code_q;
	logic [bdve_pkg::STEP_W-1:0]   step_q;
	logic                          out_valid_q;
	bdve_pkg::out_item_t           out_q;

	logic                          adv;
	logic                          emit;
	logic                          last_step;
	logic                          byte_phase;
	logic [bdve_pkg::STEP_W-1:0]   total;
	bdve_pkg::out_item_t           item;

	always_comb begin
		adv        = !out_valid_q || pop;
		emit       = cur_valid_q && adv;
		total      = cur_q.nbytes + bdve_pkg::STEP_W'(cur_q.closes)
			+ bdve_pkg::STEP_W'(cur_q.emit_last);
		last_step  = (step_q == total - bdve_pkg::STEP_W'(1));
		byte_phase = (step_q < cur_q.nbytes);
		deq        = !q_empty && (!cur_valid_q || (emit && last_step));

		item.run_last = last_step;
		if (byte_phase) begin
			item.kind    = bdve_pkg::KIND_DATA;
			item.payload = {24'd0, (step_q != cur_q.nbytes - bdve_pkg::STEP_W'(1)),
				code_q[6:0]};
		end else if (step_q == cur_q.nbytes && cur_q.closes) begin
			item.kind    = bdve_pkg::KIND_COUNT;
			item.payload = {{(bdve_pkg::VALUE_W-bdve_pkg::BYTES_W){1'b0}}, cur_q.count};
		end else begin
			item.kind    = bdve_pkg::KIND_LAST;
			item.payload = cur_q.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (deq) begin
				cur_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (emit && last_step) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + bdve_pkg::STEP_W'(1);
			end

			if (emit)     out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			cur_q  <= head;
			code_q <= head.code;
		end else if (emit && byte_phase) begin
			code_q <= code_q >> 7;
		end
		if (emit) out_q <= item;
	end

	assign result         = out_q;
	assign empty          = !out_valid_q;
	assign stat.cur_valid = cur_valid_q;
	assign stat.step      = step_q;
	assign stat.total     = total;

endmodule

// ----- design/block_delta_varbyte_encoder_unit.sv -----
// block_delta_varbyte_encoder_unit: top level of the block delta varbyte encoder.
// Depends on bdve_pkg, bdve_front, bdve_queue, bdve_back.
//
// Usage:
//  - Input channel: a request (value, list_end) on req is taken at a rising edge with
//    push high and full low. Output channel: the oldest result sits on result while
//    empty is low and is taken at a rising edge with pop high.
//  - Each request yields 1 to 5 code bytes (kind 0, low 7-bit group first, bit 7 set
//    on all but the last), then on block close the byte count (kind 1) and, in
//    running-delta mode, the block's last value (kind 2). run_last marks the final
//    result of a request.
//  - delta_mode is written through cfg_wr_en/cfg_wr_data with the block idle.
//  - A taken request passes the queue and the back end's request and output registers.
//  - Throughput: the back end emits one result per cycle while the receiver pops each
//    result, and a request has 1 to 7 results (5 to 7 for full-width deltas). The
//    front takes one request per cycle until the 4-entry queue fills.
//  - Receiver stall: the output register holds its result; the back end stops, the
//    queue fills and full rises. Nothing is dropped.
//  - Reset: arst_n clears mode, previous value, block fill and byte count, and empties
//    the queue and output register. No clearing pass is needed.
module block_delta_varbyte_encoder_unit #(
	parameter int BLOCK_LEN   = bdve_pkg::BLOCK_LEN_DEF,
	parameter int QUEUE_DEPTH = bdve_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bdve_pkg::in_item_t  req,
	input  logic                push,
	output logic                full,
	output bdve_pkg::out_item_t result,
	output logic                empty,
	input  logic                pop,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_wr_data
);

	logic [1:0]           delta_mode_q;
	logic                 accept;
	bdve_pkg::job_t       front_job;
	bdve_pkg::job_t       head_job;
	logic                 q_full;
	logic                 q_empty;
	logic                 deq;
	bdve_pkg::back_stat_t back_stat;

	// mode register; the user must write it only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_mode_q <= bdve_pkg::MODE_RUN;
		end else if (cfg_wr_en) begin
			delta_mode_q <= cfg_wr_data;
		end
	end

	assign full   = q_full;
	assign accept = push && !q_full;

	// front: delta, byte length, block bookkeeping
	bdve_front #(
		.BLOCK_LEN (BLOCK_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_item    (req),
		.accept     (accept),
		.delta_mode (delta_mode_q),
		.job        (front_job)
	);

	// decoupling queue
	bdve_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wr_job (front_job),
		.rd     (deq),
		.rd_job (head_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: serializes each request into results
	bdve_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head_job),
		.q_empty (q_empty),
		.deq     (deq),
		.result  (result),
		.empty   (empty),
		.pop     (pop),
		.stat    (back_stat)
	);

`ifndef SYNTHESIS
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue full and empty at once");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.cur_valid |-> (back_stat.step < back_stat.total))
		else $error("back end step past its result count");

	a_cont_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == bdve_pkg::KIND_DATA && result.payload[7])
		|-> !result.run_last)
		else $error("continuation byte marked as final result");

	a_deq_ready: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> !q_empty)
		else $error("dequeue from empty queue");
`endif

endmodule
